>>> design/mrect_pkg.sv
package mrect_pkg;

  // default sizes
  localparam int MAX_COLS_DEF = 64;
  localparam int MAX_ROWS_DEF = 1024;

  // column count register
  localparam int NCOLS_W = 7;
  localparam logic [NCOLS_W-1:0] NCOLS_RST = 7'd64;

  // row width on the input stream
  localparam int ROW_W = 64;

  // result area, saturating
  localparam int AREA_W = 17;
  localparam logic [AREA_W-1:0] AREA_MAX = 17'h1FFFF;
  localparam int OUT_DATA_W = 24;

  // row sequencer
  typedef enum logic [2:0] {
    S_IDLE,
    S_RIGHT,
    S_LEFT,
    S_DRAIN,
    S_OUT
  } state_t;

endpackage

>>> design/maximal_rectangle_of_ones.sv
// each row takes a right-to-left pass that fills the run memory, then a left-to-right pass
//   that feeds the multiplier; the set state of the last two columns decides how long the
//   pipeline takes to drain; a new row is accepted only after the result of the last one
//   has been loaded into the output register
// the next row is accepted while a result still waits in the output register
// reset: synchronous, clears the sequencer, column valid bits and best area; num_cols = 64
module maximal_rectangle_of_ones #(
  parameter int MAX_COLS = mrect_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = mrect_pkg::MAX_ROWS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  // configuration: num_cols
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [mrect_pkg::NCOLS_W-1:0]      cfg_data,
  // row requests
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [mrect_pkg::ROW_W-1:0]        s_axis_tdata,  // [63:0] row_bits
  input  logic                               s_axis_tlast,  // last_row
  // results
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [mrect_pkg::OUT_DATA_W-1:0]   m_axis_tdata,  // [16:0] best_area, rest zero
  output logic                               m_axis_tlast   // matrix_done
);

  localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int EW = CW;
  localparam int SW = EW + 1;
  localparam int HW = $clog2(MAX_ROWS + 1);
  localparam int PW = SW + HW;
  localparam int XW = PW + mrect_pkg::AREA_W;
  localparam logic [CW-1:0] COL_LAST = CW'(MAX_COLS - 1);
  localparam logic [HW:0] HMAX = (HW + 1)'(MAX_ROWS);

  // configuration register
  logic [mrect_pkg::NCOLS_W-1:0] num_cols;
  logic [mrect_pkg::NCOLS_W-1:0] ncols;
  logic [MAX_COLS-1:0]           col_mask;

  // sequencer
  mrect_pkg::state_t state, state_next;
  logic [CW-1:0] col, col_next;
  logic          ld_out;

  // row being worked on
  logic [MAX_COLS-1:0] row;
  logic                lastr;
  logic [EW-1:0]       rcnt;
  logic [EW-1:0]       lcnt;

  // memories: right runs and column state
  logic [EW-1:0] rmem [MAX_COLS];
  logic [HW-1:0] hmem [MAX_COLS];
  logic [EW-1:0] lxmem [MAX_COLS];
  logic [EW-1:0] rxmem [MAX_COLS];
  logic [EW-1:0] rq;
  logic [HW-1:0] hq;
  logic [EW-1:0] lxq;
  logic [EW-1:0] rxq;
  logic [MAX_COLS-1:0] vld;

  // pipeline: issue, extent, multiply, compare
  logic          a_vld;
  logic [CW-1:0] a_col;
  logic          a_bit;
  logic [EW-1:0] a_lrun;
  logic          b_vld;
  logic [SW-1:0] b_sum;
  logic [HW-1:0] b_h;
  logic          c_vld;
  logic [PW-1:0] c_prod;

  logic [HW-1:0] old_h;
  logic [HW:0]   h_inc;
  logic [HW-1:0] new_h;
  logic [EW-1:0] new_l;
  logic [EW-1:0] new_r;
  logic [mrect_pkg::AREA_W-1:0] area;
  logic [mrect_pkg::AREA_W-1:0] best;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == mrect_pkg::S_IDLE);

  // column count write
  always_ff @(posedge clk) begin
    if (rst) begin
      num_cols <= mrect_pkg::NCOLS_RST;
    end else if (cfg_valid && cfg_ready) begin
      num_cols <= cfg_data;
    end
  end

  // mask of columns in use
  always_comb begin
    ncols = (num_cols > mrect_pkg::NCOLS_W'(MAX_COLS)) ? mrect_pkg::NCOLS_W'(MAX_COLS)
                                                        : num_cols;
    for (int j = 0; j < MAX_COLS; j++) begin
      col_mask[j] = (mrect_pkg::NCOLS_W'(j) < ncols);
    end
  end

  // next state
  always_comb begin
    state_next = state;
    col_next   = col;
    ld_out     = 1'b0;
    case (state)
      mrect_pkg::S_IDLE: begin
        if (s_axis_tvalid) begin
          state_next = mrect_pkg::S_RIGHT;
          col_next   = COL_LAST;
        end
      end
      mrect_pkg::S_RIGHT: begin
        if (col == '0) begin
          state_next = mrect_pkg::S_LEFT;
        end else begin
          col_next = col - 1'b1;
        end
      end
      mrect_pkg::S_LEFT: begin
        if (col == COL_LAST) begin
          state_next = mrect_pkg::S_DRAIN;
        end else begin
          col_next = col + 1'b1;
        end
      end
      mrect_pkg::S_DRAIN: begin
        if (!a_vld && !b_vld && !c_vld) begin
          state_next = mrect_pkg::S_OUT;
        end
      end
      mrect_pkg::S_OUT: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          ld_out     = 1'b1;
          state_next = mrect_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = mrect_pkg::S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mrect_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
    col <= col_next;
  end

  // row capture and run counters
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      row   <= s_axis_tdata[MAX_COLS-1:0] & col_mask;
      lastr <= s_axis_tlast;
      rcnt  <= '0;
      lcnt  <= '0;
    end else if (state == mrect_pkg::S_RIGHT) begin
      rcnt <= row[col] ? rcnt + 1'b1 : '0;
    end else if (state == mrect_pkg::S_LEFT) begin
      lcnt <= row[col] ? lcnt + 1'b1 : '0;
    end
  end

  // right run memory
  always_ff @(posedge clk) begin
    if (state == mrect_pkg::S_RIGHT) begin
      rmem[col] <= rcnt;
    end
    rq <= rmem[col];
  end

  // issue stage
  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else begin
      a_vld <= (state == mrect_pkg::S_LEFT);
    end
    a_col  <= col;
    a_bit  <= row[col];
    a_lrun <= lcnt;
  end

  // extents and height of the column
  always_comb begin
    old_h = vld[a_col] ? hq : '0;
    h_inc = {1'b0, old_h} + 1'b1;
    new_h = (h_inc > HMAX) ? HMAX[HW-1:0] : h_inc[HW-1:0];
    new_l = a_lrun;
    new_r = rq;
    if (old_h != '0) begin
      if (lxq < a_lrun) begin
        new_l = lxq;
      end
      if (rxq < rq) begin
        new_r = rxq;
      end
    end
  end

  // column state memories, zeroed on an empty cell and on the last row
  always_ff @(posedge clk) begin
    if (a_vld) begin
      if (a_bit && !lastr) begin
        hmem[a_col]  <= new_h;
        lxmem[a_col] <= new_l;
        rxmem[a_col] <= new_r;
      end else begin
        hmem[a_col]  <= '0;
        lxmem[a_col] <= '0;
        rxmem[a_col] <= '0;
      end
    end
    hq  <= hmem[col];
    lxq <= lxmem[col];
    rxq <= rxmem[col];
  end

  // valid bits stand for the reset value of the column state
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (a_vld) begin
      vld[a_col] <= 1'b1;
    end
  end

  // width and height, then the shared multiplier
  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
      c_vld <= 1'b0;
    end else begin
      b_vld <= a_vld && a_bit;
      c_vld <= b_vld;
    end
    b_sum  <= SW'(new_l) + SW'(new_r) + 1'b1;
    b_h    <= new_h;
    c_prod <= PW'(b_sum) * PW'(b_h);
  end

  // saturate and keep the best
  assign area = (XW'(c_prod) > XW'(mrect_pkg::AREA_MAX)) ? mrect_pkg::AREA_MAX
                                                          : mrect_pkg::AREA_W'(c_prod);

  always_ff @(posedge clk) begin
    if (rst) begin
      best <= '0;
    end else if (ld_out && lastr) begin
      best <= '0;
    end else if (c_vld && (area > best)) begin
      best <= area;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (ld_out) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
    if (ld_out) begin
      m_axis_tdata <= mrect_pkg::OUT_DATA_W'(best);
      m_axis_tlast <= lastr;
    end
  end

  // the result is taken only once the pipeline has drained
  a_drained: assert property (@(posedge clk) disable iff (rst)
    (state == mrect_pkg::S_OUT) |-> (!a_vld && !b_vld && !c_vld))
    else $error("result loaded with columns still in flight");

  // the best area never falls while a row is being worked
  a_best_mono: assert property (@(posedge clk) disable iff (rst)
    c_vld |=> (best >= $past(best)))
    else $error("best area decreased");

  // issue stage only follows the left-to-right pass
  a_issue: assert property (@(posedge clk) disable iff (rst)
    a_vld |-> ($past(state) == mrect_pkg::S_LEFT))
    else $error("column issued outside the left pass");

endmodule

>>> tb/mrect_area_checker.sv
module mrect_area_checker (
  input  logic                             clk,
  input  logic                             rst,
  // configuration channel
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [mrect_pkg::NCOLS_W-1:0]    cfg_data,
  // row requests
  input  logic                             row_valid,
  input  logic                             row_ready,
  input  logic [mrect_pkg::ROW_W-1:0]      row_bits,    // [63:0] row_bits
  input  logic                             row_last,    // last_row
  // area results
  input  logic                             res_valid,
  input  logic                             res_ready,
  input  logic [mrect_pkg::OUT_DATA_W-1:0] res_data,    // [16:0] best_area, rest zero
  input  logic                             res_last,    // matrix_done
  output int                               mismatches,
  output int                               pending,
  output int                               results_seen,
  output int                               peak_area
);
  timeunit 1ns;
  timeprecision 1ps;
  import mrect_pkg::*;

  localparam int HEIGHT_W = 11;
  localparam int EXT_W = 6;

  typedef struct packed {
    logic [AREA_W-1:0] area;
    logic              done;
  } area_due_t;

  // per-column histogram and extents carried from the previous row
  logic [HEIGHT_W-1:0] col_height [ROW_W];
  logic [EXT_W-1:0]    ext_left   [ROW_W];
  logic [EXT_W-1:0]    ext_right  [ROW_W];
  logic [AREA_W-1:0]   best_so_far;
  logic [NCOLS_W-1:0]  cols_in_use;

  area_due_t area_due_q [$];
  int bad_cnt;
  int seen_cnt;
  int peak;

  task automatic clear_matrix();
    for (int j = 0; j < ROW_W; j++) begin
      col_height[j] = '0;
      ext_left[j] = '0;
      ext_right[j] = '0;
    end
    best_so_far = '0;
  endtask

  // fold one row into the histogram and return the best area so far
  task automatic advance_rows(input logic [ROW_W-1:0] bits, input logic last,
                              output area_due_t due);
    int unsigned ncols;
    int unsigned l;
    int unsigned r;
    int unsigned h;
    int unsigned area;
    int unsigned run_l [ROW_W];
    int unsigned run_r [ROW_W];
    logic [ROW_W-1:0] row;
    ncols = (cols_in_use > MAX_COLS_DEF) ? MAX_COLS_DEF : cols_in_use;
    row = (ncols >= ROW_W) ? bits : bits & ((64'd1 << ncols) - 64'd1);

    // runs of ones beside each column in this row
    run_l[0] = 0;
    for (int j = 1; j < ROW_W; j++)
      run_l[j] = row[j-1] ? run_l[j-1] + 1 : 0;
    run_r[ROW_W-1] = 0;
    for (int j = ROW_W - 2; j >= 0; j--)
      run_r[j] = row[j+1] ? run_r[j+1] + 1 : 0;

    for (int j = 0; j < ROW_W; j++) begin
      if (!row[j]) begin
        col_height[j] = '0;
        ext_left[j] = '0;
        ext_right[j] = '0;
      end else begin
        l = run_l[j];
        r = run_r[j];
        // a set cell above narrows the extents to the column's previous ones
        if (col_height[j] != 0) begin
          if (ext_left[j] < l) l = ext_left[j];
          if (ext_right[j] < r) r = ext_right[j];
        end
        h = col_height[j] + 1;
        if (h > MAX_ROWS_DEF) h = MAX_ROWS_DEF;
        col_height[j] = HEIGHT_W'(h);
        ext_left[j] = EXT_W'(l);
        ext_right[j] = EXT_W'(r);
        area = (l + r + 1) * h;
        if (area > AREA_MAX) area = AREA_MAX;
        if (area > best_so_far) best_so_far = AREA_W'(area);
      end
    end

    due.area = best_so_far;
    due.done = last;
    if (last) clear_matrix();
  endtask

  task automatic flag(input string what, input string want_s, input string got_s);
    bad_cnt++;
    if (bad_cnt <= 10)
      $display("mismatch %0d at result %0d: %s expected %s got %s",
               bad_cnt, seen_cnt, what, want_s, got_s);
  endtask

  // watch the three channels, predict on row requests, compare on results
  always @(posedge clk) begin
    area_due_t due;
    area_due_t want;
    if (rst) begin
      clear_matrix();
      cols_in_use = NCOLS_RST;
      area_due_q.delete();
      bad_cnt = 0;
      seen_cnt = 0;
      peak = 0;
    end else begin
      if (cfg_valid && cfg_ready)
        cols_in_use = cfg_data;
      if (res_valid && res_ready) begin
        seen_cnt++;
        if (area_due_q.size() == 0) begin
          flag("result with no row outstanding", "none",
               $sformatf("best_area %0d matrix_done %0b", res_data, res_last));
        end else begin
          want = area_due_q.pop_front();
          if (res_data !== OUT_DATA_W'(want.area))
            flag("best_area", $sformatf("%0d", want.area), $sformatf("%0d", res_data));
          if (res_last !== want.done)
            flag("matrix_done", $sformatf("%0b", want.done), $sformatf("%0b", res_last));
          if (want.area > peak) peak = want.area;
        end
      end
      if (row_valid && row_ready) begin
        advance_rows(row_bits, row_last, due);
        area_due_q.push_back(due);
      end
    end
    mismatches <= bad_cnt;
    pending <= area_due_q.size();
    results_seen <= seen_cnt;
    peak_area <= peak;
  end

endmodule

>>> tb/tb_maximal_rectangle_of_ones.sv
module tb_maximal_rectangle_of_ones;
  timeunit 1ns;
  timeprecision 1ps;
  import mrect_pkg::*;

  localparam int ROW_LATENCY = 2 * MAX_COLS_DEF + 5;
  localparam int IDLE_LIMIT = 20000;
  localparam int HOLD_CYCLES = 900;
  localparam int TALL_ROWS = MAX_ROWS_DEF + 6;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ROWS = 20;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [NCOLS_W-1:0]    cfg_data = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [ROW_W-1:0]      s_axis_tdata = '0;   // [63:0] row_bits
  logic                  s_axis_tlast = 1'b0; // last_row
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;        // [16:0] best_area, rest zero
  logic                  m_axis_tlast;        // matrix_done

  int mismatches;
  int pending;
  int results_seen;
  int peak_area;

  // stimulus bookkeeping
  int   burst_left = 0;
  int   rows_sent = 0;
  int   matrices_closed = 0;
  int   depth_now = 0;
  int   deepest = 0;
  int   cols_writes = 0;
  int   stuck_cycles = 0;
  logic hold_req = 1'b0;

  always #2 clk = ~clk;

  maximal_rectangle_of_ones uut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast)
  );

  mrect_area_checker area_check (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .row_valid(s_axis_tvalid),
    .row_ready(s_axis_tready),
    .row_bits(s_axis_tdata),
    .row_last(s_axis_tlast),
    .res_valid(m_axis_tvalid),
    .res_ready(m_axis_tready),
    .res_data(m_axis_tdata),
    .res_last(m_axis_tlast),
    .mismatches(mismatches),
    .pending(pending),
    .results_seen(results_seen),
    .peak_area(peak_area)
  );

  // offer one row request, then maybe a gap once the burst runs out
  task automatic send_row(input logic [ROW_W-1:0] bits, input logic last);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= bits;
    s_axis_tlast <= last;
    do @(posedge clk); while (!s_axis_tready);
    rows_sent++;
    depth_now++;
    if (last) begin
      matrices_closed++;
      if (depth_now > deepest) deepest = depth_now;
      depth_now = 0;
    end
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 40);
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 200) : $urandom_range(0, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // column count is only changed once every row has been answered
  task automatic write_cols(input logic [NCOLS_W-1:0] value);
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (ROW_LATENCY) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cols_writes++;
  endtask

  // mostly dense rows and rows close to the previous one, so rectangles grow
  function automatic logic [ROW_W-1:0] random_row(input logic [ROW_W-1:0] prev);
    logic [ROW_W-1:0] a;
    logic [ROW_W-1:0] b;
    logic [ROW_W-1:0] c;
    int lo;
    int hi;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    c = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0, 1: return a;
      2, 3: return a | b;
      4: return a | b | c;
      5: return a & b;
      6: begin
        lo = $urandom_range(0, ROW_W - 1);
        hi = $urandom_range(lo, ROW_W - 1);
        return ({ROW_W{1'b1}} << lo) & ({ROW_W{1'b1}} >> (ROW_W - 1 - hi));
      end
      7, 8: return prev ^ (64'd1 << $urandom_range(0, ROW_W - 1))
                        ^ ((64'd1 << $urandom_range(0, ROW_W - 1)) & {ROW_W{a[0]}});
      default: return a[1] ? '1 : '0;
    endcase
  endfunction

  task automatic send_matrix(input int height, input logic close);
    logic [ROW_W-1:0] bits;
    bits = '0;
    for (int r = 0; r < height; r++) begin
      bits = random_row(bits);
      send_row(bits, close && (r == height - 1));
    end
  endtask

  // extremes first, then random column counts with an occasional oversize one
  function automatic logic [NCOLS_W-1:0] phase_cols(input int ph);
    case (ph)
      0: return NCOLS_W'(64);
      1: return NCOLS_W'(1);
      2: return NCOLS_W'(127);
      3: return NCOLS_W'(0);
      4: return NCOLS_W'(63);
      5: return NCOLS_W'(2);
      6: return NCOLS_W'(65);
      7: return NCOLS_W'(33);
      default: return ($urandom_range(0, 9) == 0) ? NCOLS_W'($urandom_range(65, 127))
                                                  : NCOLS_W'($urandom_range(1, 64));
    endcase
  endfunction

  // stimulus and verdict
  initial begin : stimulus
    int height;
    int phase_rows;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // full width at the reset column count, extreme columns, checkerboard
    send_row('1, 1'b0);
    send_row('1, 1'b1);
    send_row('0, 1'b1);
    send_row(64'h8000_0000_0000_0000, 1'b1);
    send_row(64'h0000_0000_0000_0001, 1'b1);
    send_row({32{2'b10}}, 1'b0);
    send_row({32{2'b01}}, 1'b1);
    // wide row under a narrow one, then a narrow row inside the wide one
    send_row(64'h0000_0000_0000_0FF0, 1'b0);
    send_row(64'h0000_0000_000F_FFFF, 1'b0);
    send_row(64'h0000_0000_0000_3C00, 1'b1);
    // no columns in use, oversize count, single column, just above the maximum
    write_cols(NCOLS_W'(0));
    send_row('1, 1'b1);
    write_cols(NCOLS_W'(127));
    send_row('1, 1'b1);
    write_cols(NCOLS_W'(1));
    send_row('1, 1'b0);
    send_row('1, 1'b1);
    write_cols(NCOLS_W'(65));
    send_row(64'hFFFF_FFFF_0000_FFFF, 1'b1);
    // column count shrinks in the middle of a matrix
    write_cols(NCOLS_W'(64));
    send_row('1, 1'b0);
    send_row('1, 1'b0);
    write_cols(NCOLS_W'(8));
    send_row('1, 1'b1);

    // random matrices, some left open across a column count change
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      write_cols(phase_cols(ph));
      if (ph == 0) hold_req <= 1'b1;
      phase_rows = 0;
      while (phase_rows < PHASE_ROWS) begin
        height = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 8);
        send_matrix(height, 1'b1);
        phase_rows += height;
      end
      if ($urandom_range(0, 3) == 0) send_matrix($urandom_range(1, 4), 1'b0);
    end

    // tall full-width matrix drives the heights into saturation
    write_cols(NCOLS_W'(64));
    for (int r = 0; r < TALL_ROWS; r++)
      send_row((r < TALL_ROWS - 4) ? '1 : random_row('1), r == TALL_ROWS - 1);

    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (ROW_LATENCY + 8) @(posedge clk);

    $display("covered %0d rows in %0d closed matrices (deepest %0d rows), %0d column-count writes",
             rows_sent, matrices_closed, deepest, cols_writes);
    $display("checked %0d results, largest area %0d, %0d mismatches",
             results_seen, peak_area, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // result side: changing stall patterns plus one long hold-off
  initial begin : result_sink
    int   mode;
    int   span;
    int   tick;
    int   stall_left;
    logic hold_taken;
    tick = 0;
    stall_left = 0;
    hold_taken = 1'b0;
    forever begin
      mode = $urandom_range(0, 4);
      span = $urandom_range(50, 400);
      repeat (span) begin
        @(posedge clk);
        tick++;
        if (hold_req && !hold_taken) begin
          hold_taken = 1'b1;
          m_axis_tready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk);
        end
        case (mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= ($urandom_range(0, 1) == 1);
          2: m_axis_tready <= (tick % 4 == 0);
          3: m_axis_tready <= ($urandom_range(0, 9) != 0);
          default: begin
            if (stall_left > 0) begin
              stall_left--;
              m_axis_tready <= 1'b0;
            end else begin
              m_axis_tready <= 1'b1;
              if ($urandom_range(0, 49) == 0) stall_left = $urandom_range(50, 300);
            end
          end
        endcase
      end
    end
  end

  // watchdog on cycles with no request moving on any channel
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles == IDLE_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

endmodule
